### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property shapes for the block averager checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GCBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcba assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GCBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcba assertion failed");

`endif

### rtl/gcba_pkg.sv
// ---------------------------------------------------------------------------
// gcba_pkg
// Types and constants shared by the gated channel block averager.
// ---------------------------------------------------------------------------
package gcba_pkg;

  localparam int CH_W        = 5;   // channel field width
  localparam int SIZE_W      = 8;   // averaging size and frame count width
  localparam int SAMPLE_W    = 16;  // feature field width
  localparam int IN_FEATURES = 8;   // features carried by one frame
  localparam int FIDX_W      = 3;   // index into the frame features
  localparam int GATE0_TIME  = 0;
  localparam int GATE3_TIME  = 6;

  localparam logic OP_FRAME    = 1'b0;
  localparam logic OP_SET_SIZE = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_PASS,
    S_ACC_RD,
    S_ACC_WR,
    S_COUNT,
    S_DIV_RD,
    S_DIV_LD,
    S_DIV_WAIT,
    S_EMIT
  } state_e;

endpackage

### rtl/gcba_div.sv
// ---------------------------------------------------------------------------
// gcba_div
// Restoring radix-2 divider: one quotient bit per cycle, unsigned operands.
// ---------------------------------------------------------------------------
module gcba_div #(
  parameter int DW = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DW-1:0]               dividend_i,
  input  logic [gcba_pkg::SIZE_W-1:0] divisor_i,
  output logic [DW-1:0]               quot_o,
  output logic                        done_o
);

  localparam int CNT_W = $clog2(DW);

  logic [DW-1:0]               dvd_q;
  logic [gcba_pkg::SIZE_W-1:0] dsr_q;
  logic [gcba_pkg::SIZE_W-1:0] rem_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q;
  logic                        done_q;

  logic [gcba_pkg::SIZE_W:0]   rem_sh;
  logic [gcba_pkg::SIZE_W:0]   rem_sub;
  logic                        fits;

  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign fits    = (rem_sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient bits shift in from the bottom as dividend bits leave the top
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], fits};
      rem_q <= fits ? rem_sub[gcba_pkg::SIZE_W-1:0] : rem_sh[gcba_pkg::SIZE_W-1:0];
    end
  end

  assign quot_o = dvd_q;
  assign done_o = done_q;

endmodule

### rtl/gated_channel_block_averager.sv
// ---------------------------------------------------------------------------
// gated_channel_block_averager
// Per-channel block averager for ultrasonic gate feature frames.
// ---------------------------------------------------------------------------
// One item at a time. A set-size transfer leaves the sequencer idle, so the
// next item can follow right away. A dropped frame goes through transfer and
// table lookup, and a pass-through frame through transfer, lookup and output
// load. A frame that only adds to the sums goes through transfer and lookup,
// then a read and then a write of each sum on the single port of the sum
// memory, then the count update. A frame that closes an average then runs the
// shared serial divider that produces one quotient bit per cycle, one feature
// after another. Beyond these steps the sequencer holds only while a finished
// result waits in the output register. There is no clearing pass: per-channel
// valid bits stand in for the zeroed sums and counts and for the default size
// of one.
module gated_channel_block_averager #(
  parameter int CHANNELS    = 32,
  parameter int FEATURES    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [gcba_pkg::CH_W-1:0]     channel_i,
  input  logic [gcba_pkg::SIZE_W-1:0]   avg_size_i,
  input  gcba_pkg::sample_t             feature_0_i,
  input  gcba_pkg::sample_t             feature_1_i,
  input  gcba_pkg::sample_t             feature_2_i,
  input  gcba_pkg::sample_t             feature_3_i,
  input  gcba_pkg::sample_t             feature_4_i,
  input  gcba_pkg::sample_t             feature_5_i,
  input  gcba_pkg::sample_t             feature_6_i,
  input  gcba_pkg::sample_t             feature_7_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gcba_pkg::CH_W-1:0]     out_channel_o,
  output gcba_pkg::sample_t             avg_0_o,
  output gcba_pkg::sample_t             avg_1_o,
  output gcba_pkg::sample_t             avg_2_o,
  output gcba_pkg::sample_t             avg_3_o,
  output gcba_pkg::sample_t             avg_4_o,
  output gcba_pkg::sample_t             avg_5_o,
  output gcba_pkg::sample_t             avg_6_o,
  output gcba_pkg::sample_t             avg_7_o
);

  localparam int NF        = gcba_pkg::IN_FEATURES;
  localparam int SUM_W     = SAMPLE_BITS + 8;
  localparam int CH_IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_DEPTH = CHANNELS * FEATURES;
  localparam int SA_W      = $clog2(SUM_DEPTH);
  localparam int FI_W      = $clog2(FEATURES);
  localparam int MASK_BITS = (SAMPLE_BITS < gcba_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                 : gcba_pkg::SAMPLE_W;
  localparam gcba_pkg::sample_t SAMPLE_MASK =
    gcba_pkg::sample_t'((17'd1 << MASK_BITS) - 17'd1);
  localparam logic [FI_W-1:0] J_LAST = FI_W'(FEATURES - 1);

  gcba_pkg::state_e state_q, state_d;

  logic [gcba_pkg::CH_W-1:0]   ch_q, ch_d;
  gcba_pkg::sample_t           f_q [NF];
  gcba_pkg::sample_t           f_d [NF];
  logic [FI_W-1:0]             j_q, j_d;
  logic [gcba_pkg::SIZE_W-1:0] cnt_q, cnt_d;
  logic [gcba_pkg::SIZE_W-1:0] size_q, size_d;
  logic [CHANNELS-1:0]         size_vld_q, size_vld_d;
  logic [CHANNELS-1:0]         acc_vld_q, acc_vld_d;

  logic [SUM_W-1:0]            sum_mem  [SUM_DEPTH];
  logic [gcba_pkg::SIZE_W-1:0] cnt_mem  [CHANNELS];
  logic [gcba_pkg::SIZE_W-1:0] size_mem [CHANNELS];
  logic [SUM_W-1:0]            sum_rd_q;
  logic [gcba_pkg::SIZE_W-1:0] cnt_rd_q;
  logic [gcba_pkg::SIZE_W-1:0] size_rd_q;

  logic                        out_vld_q;
  logic [gcba_pkg::CH_W-1:0]   out_ch_q;
  gcba_pkg::sample_t           out_avg_q [NF];

  gcba_pkg::sample_t           in_feat [NF];
  logic [CH_IW+gcba_pkg::CH_W-1:0] in_ch_ext, ch_ext;
  logic [CH_IW-1:0]            in_idx, idx;
  logic                        in_ch_ok, ch_ok;
  logic                        in_acc;
  logic                        out_free;
  logic [gcba_pkg::FIDX_W-1:0] fj;
  logic [SA_W-1:0]             sum_addr;
  logic [SUM_W-1:0]            sum_wdata;
  logic                        sum_we, cnt_we, size_we;
  logic [gcba_pkg::SIZE_W-1:0] size_now, cnt_now, cnt_new;
  logic                        div_start, div_done;
  logic [SUM_W-1:0]            div_quot;
  logic                        out_load, out_emit;

  assign in_feat[0] = feature_0_i;
  assign in_feat[1] = feature_1_i;
  assign in_feat[2] = feature_2_i;
  assign in_feat[3] = feature_3_i;
  assign in_feat[4] = feature_4_i;
  assign in_feat[5] = feature_5_i;
  assign in_feat[6] = feature_6_i;
  assign in_feat[7] = feature_7_i;

  assign in_ch_ext = {{CH_IW{1'b0}}, channel_i};
  assign ch_ext    = {{CH_IW{1'b0}}, ch_q};
  assign in_idx    = in_ch_ext[CH_IW-1:0];
  assign idx       = ch_ext[CH_IW-1:0];
  assign in_ch_ok  = (int'(channel_i) < CHANNELS);
  assign ch_ok     = (int'(ch_q) < CHANNELS);

  assign in_stall_o = (state_q != gcba_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;

  assign fj        = gcba_pkg::FIDX_W'(j_q);
  assign sum_addr  = SA_W'(int'(idx) * FEATURES + int'(j_q));
  // a channel without a valid row counts as holding sums of zero
  assign sum_wdata = (acc_vld_q[idx] ? sum_rd_q : '0) + SUM_W'(f_q[fj]);
  assign size_now  = (ch_ok && size_vld_q[idx]) ? size_rd_q : gcba_pkg::SIZE_W'(1);
  assign cnt_now   = acc_vld_q[idx] ? cnt_rd_q : '0;
  assign cnt_new   = cnt_q + 1'b1;

  gcba_div #(
    .DW(SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_rd_q),
    .divisor_i  (cnt_q),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    f_d        = f_q;
    j_d        = j_q;
    cnt_d      = cnt_q;
    size_d     = size_q;
    size_vld_d = size_vld_q;
    acc_vld_d  = acc_vld_q;
    sum_we     = 1'b0;
    cnt_we     = 1'b0;
    size_we    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    out_emit   = 1'b0;

    unique case (state_q)
      gcba_pkg::S_IDLE: begin
        if (in_acc) begin
          if (op_i == gcba_pkg::OP_SET_SIZE) begin
            if (in_ch_ok) begin
              size_we            = 1'b1;
              size_vld_d[in_idx] = 1'b1;
            end
          end else begin
            ch_d = channel_i;
            for (int k = 0; k < NF; k++) begin
              f_d[k] = in_feat[k] & SAMPLE_MASK;
            end
            state_d = gcba_pkg::S_LOOKUP;
          end
        end
      end
      gcba_pkg::S_LOOKUP: begin
        size_d = size_now;
        cnt_d  = cnt_now;
        if (size_now <= gcba_pkg::SIZE_W'(1)) begin
          state_d = gcba_pkg::S_PASS;
        end else if (f_q[gcba_pkg::GATE0_TIME] == '0 || f_q[gcba_pkg::GATE3_TIME] == '0) begin
          state_d = gcba_pkg::S_IDLE;
        end else begin
          j_d     = '0;
          state_d = gcba_pkg::S_ACC_RD;
        end
      end
      gcba_pkg::S_PASS: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = gcba_pkg::S_IDLE;
        end
      end
      gcba_pkg::S_ACC_RD: begin
        state_d = gcba_pkg::S_ACC_WR;
      end
      gcba_pkg::S_ACC_WR: begin
        sum_we = 1'b1;
        if (j_q == J_LAST) begin
          state_d = gcba_pkg::S_COUNT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = gcba_pkg::S_ACC_RD;
        end
      end
      gcba_pkg::S_COUNT: begin
        cnt_we         = 1'b1;
        acc_vld_d[idx] = 1'b1;
        if (cnt_new == '0 || cnt_new < size_q) begin
          state_d = gcba_pkg::S_IDLE;
        end else begin
          cnt_d   = cnt_new;
          j_d     = '0;
          state_d = gcba_pkg::S_DIV_RD;
        end
      end
      gcba_pkg::S_DIV_RD: begin
        state_d = gcba_pkg::S_DIV_LD;
      end
      gcba_pkg::S_DIV_LD: begin
        div_start = 1'b1;
        state_d   = gcba_pkg::S_DIV_WAIT;
      end
      gcba_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          // quotient overwrites the consumed sample slot
          f_d[fj] = div_quot[gcba_pkg::SAMPLE_W-1:0];
          if (j_q == J_LAST) begin
            state_d = gcba_pkg::S_EMIT;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = gcba_pkg::S_DIV_RD;
          end
        end
      end
      gcba_pkg::S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_emit       = 1'b1;
          acc_vld_d[idx] = 1'b0;
          state_d        = gcba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gcba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gcba_pkg::S_IDLE;
      size_vld_q <= '0;
      acc_vld_q  <= '0;
      j_q        <= '0;
    end else begin
      state_q    <= state_d;
      size_vld_q <= size_vld_d;
      acc_vld_q  <= acc_vld_d;
      j_q        <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    f_q    <= f_d;
    cnt_q  <= cnt_d;
    size_q <= size_d;
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wdata;
    end
    sum_rd_q <= sum_mem[sum_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[idx] <= cnt_new;
    end
    cnt_rd_q <= cnt_mem[in_idx];
  end

  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[in_idx] <= avg_size_i;
    end
    size_rd_q <= size_mem[in_idx];
  end

  // output register: holds one result while the next item is worked on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q <= ch_q;
      for (int k = 0; k < NF; k++) begin
        out_avg_q[k] <= (out_emit && k >= FEATURES) ? '0 : f_q[k];
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_channel_o = out_ch_q;
  assign avg_0_o       = out_avg_q[0];
  assign avg_1_o       = out_avg_q[1];
  assign avg_2_o       = out_avg_q[2];
  assign avg_3_o       = out_avg_q[3];
  assign avg_4_o       = out_avg_q[4];
  assign avg_5_o       = out_avg_q[5];
  assign avg_6_o       = out_avg_q[6];
  assign avg_7_o       = out_avg_q[7];

endmodule

### rtl/gcba_checker.sv
// ---------------------------------------------------------------------------
// gcba_checker
// Port-level checks for the gated channel block averager, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gcba_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      op_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [gcba_pkg::CH_W-1:0] out_channel_o,
  input gcba_pkg::sample_t         avg_0_o
);

  // a frame transfer always occupies the sequencer for the next cycle
  `GCBA_ASSERT_NXT(a_frame_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && op_i == gcba_pkg::OP_FRAME, in_stall_o)

  // a size write completes in its own cycle
  `GCBA_ASSERT_NXT(a_size_write_ready, clk_i, rst_ni, in_valid_i && !in_stall_o && op_i == gcba_pkg::OP_SET_SIZE, !in_stall_o)

  // no result can show up in the cycle after a transfer in
  `GCBA_ASSERT_NXT(a_no_early_result, clk_i, rst_ni, in_valid_i && !in_stall_o, !$rose(out_valid_o))

  `GCBA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_channel_o) && $stable(avg_0_o))

endmodule

bind gated_channel_block_averager gcba_checker u_gcba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .op_i          (op_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_channel_o (out_channel_o),
  .avg_0_o       (avg_0_o)
);
